@@ rtl/core/srg_pkg.sv @@
// Shared constants and types of the segment ramp generator.
package srg_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int VALUE_W = 32;
    localparam int DUR_W   = 16;
    localparam int RATE_W  = 10;

    localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(20);
    localparam logic [DUR_W-1:0]  ELAPSED_MAX = '1;

    localparam logic [QCNT_W-1:0] QDEPTH_CNT = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] QDEPTH_M1  = QPTR_W'(QUEUE_DEPTH - 1);

    // (target - origin) * elapsed, and its magnitude
    localparam int PROD_W = VALUE_W + 1 + DUR_W;
    localparam int MAG_W  = PROD_W - 1;
    localparam int QUOT_W = VALUE_W + 2;

    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_STEPS          = MAG_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_JUMP      = 3'd1,
        OP_NEW_LIST  = 3'd2,
        OP_APPEND    = 3'd3,
        OP_CLEAR     = 3'd4
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] target;
        logic [DUR_W-1:0]          duration;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] target;
        logic [DUR_W-1:0]          duration;
    } qent_t;

endpackage

@@ rtl/core/srg_front.sv @@
// Front end: accept and decode input transactions into a two-entry command queue.
module srg_front import srg_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_action,
    input  logic signed [VALUE_W-1:0] s_target_value,
    input  logic [DUR_W-1:0]          s_duration_ms,
    output logic                      cmd_valid,
    output cmd_t                      cmd,
    input  logic                      cmd_pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;

    assign s_ready   = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    // drop unused action codes here
    assign push = s_valid && s_ready &&
                  (s_action inside {OP_TICK, OP_JUMP, OP_NEW_LIST, OP_APPEND, OP_CLEAR});

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg].op       <= op_t'(s_action);
            slot_reg[wr_ptr_reg].target   <= s_target_value;
            slot_reg[wr_ptr_reg].duration <= s_duration_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, cmd_pop})
                2'b10: begin
                    fill_reg <= fill_reg + 2'd1;
                end
                2'b01: begin
                    fill_reg <= fill_reg - 2'd1;
                end
                default: begin
                    fill_reg <= fill_reg;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/srg_div.sv @@
// Signed divider, truncating toward zero, two quotient bits per cycle.
module srg_div import srg_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [PROD_W-1:0]  dividend,
    input  logic [DUR_W-1:0]          divisor,
    output logic                      done,
    output logic signed [QUOT_W-1:0]  quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic [MAG_W-1:0]     dq_reg;
    logic [DUR_W-1:0]     rem_reg;
    logic [DUR_W-1:0]     dsr_reg;

    logic signed [PROD_W-1:0] abs_w;
    logic [MAG_W-1:0]         dq_next;
    logic [DUR_W-1:0]         rem_next;
    logic [DUR_W:0]           trial;
    logic [QUOT_W-1:0]        q_mag;

    assign abs_w = dividend[PROD_W-1] ? -dividend : dividend;

    always_comb begin
        dq_next  = dq_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
            trial   = {rem_next, dq_next[MAG_W-1]};
            dq_next = {dq_next[MAG_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                trial      = trial - {1'b0, dsr_reg};
                dq_next[0] = 1'b1;
            end
            rem_next = trial[DUR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[PROD_W-1];
            dq_reg  <= abs_w[MAG_W-1:0];
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign q_mag    = dq_reg[QUOT_W-1:0];
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_mag) : $signed(q_mag);

endmodule

@@ rtl/core/srg_back.sv @@
// Back end: segment state, segment queue, interpolation and output register.
module srg_back import srg_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [RATE_W-1:0]         rate_ms,
    input  logic                      cmd_valid,
    input  cmd_t                      cmd,
    output logic                      cmd_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_ramp_value,
    output logic [QCNT_W-1:0]         q_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                    state_reg;
    logic signed [VALUE_W-1:0] origin_reg;
    logic signed [VALUE_W-1:0] target_reg;
    logic [DUR_W-1:0]          dur_reg;
    logic [DUR_W-1:0]          elapsed_reg;
    logic [RATE_W-1:0]         rate_cnt_reg;
    logic [QPTR_W-1:0]         head_reg;
    logic [QCNT_W-1:0]         count_reg;
    logic signed [VALUE_W-1:0] result_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      m_valid_reg;
    logic signed [VALUE_W-1:0] m_value_reg;

    qent_t mem [QUEUE_DEPTH];
    qent_t rd_reg;

    logic [DUR_W-1:0]          elapsed_inc;
    logic [RATE_W-1:0]         rate_inc;
    logic                      due;
    logic                      finished;
    logic [QCNT_W:0]           slot_sum;
    logic [QCNT_W:0]           slot_wrap;
    logic [QPTR_W-1:0]         push_slot;
    logic [QPTR_W-1:0]         head_inc;
    logic                      mem_we;
    logic [QPTR_W-1:0]         mem_addr;
    logic signed [VALUE_W:0]   diff;
    logic signed [PROD_W:0]    prod_full;
    logic                      div_start;
    logic                      div_done;
    logic signed [QUOT_W-1:0]  quotient;
    logic                      out_free;

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign rate_inc    = rate_cnt_reg + 1'b1;
    assign due         = (rate_inc >= rate_ms);
    assign finished    = (dur_reg == '0) || (elapsed_inc > dur_reg) ||
                         (elapsed_inc == ELAPSED_MAX);

    assign slot_sum  = (QCNT_W+1)'(head_reg) + (QCNT_W+1)'(count_reg);
    assign slot_wrap = (slot_sum >= (QCNT_W+1)'(QUEUE_DEPTH)) ?
                       slot_sum - (QCNT_W+1)'(QUEUE_DEPTH) : slot_sum;
    assign push_slot = slot_wrap[QPTR_W-1:0];
    assign head_inc  = (head_reg == QDEPTH_M1) ? '0 : head_reg + 1'b1;

    // a new list empties the queue first, so its entry lands in slot zero
    assign mem_we   = cmd_pop && ((cmd.op == OP_NEW_LIST) ||
                                  ((cmd.op == OP_APPEND) && (count_reg < QDEPTH_CNT)));
    assign mem_addr = (cmd.op == OP_NEW_LIST) ? '0 : push_slot;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= {cmd.target, cmd.duration};
        end
        rd_reg <= mem[head_reg];
    end

    assign diff      = {target_reg[VALUE_W-1], target_reg} - {origin_reg[VALUE_W-1], origin_reg};
    assign prod_full = diff * $signed({1'b0, elapsed_reg});
    assign div_start = (state_reg == S_DSTART);
    assign out_free  = !m_valid_reg || m_ready;

    srg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dur_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            origin_reg   <= '0;
            target_reg   <= '0;
            dur_reg      <= '0;
            elapsed_reg  <= '0;
            rate_cnt_reg <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            result_reg   <= '0;
            prod_reg     <= '0;
            m_valid_reg  <= 1'b0;
            m_value_reg  <= '0;
        end else begin
            // the emit state sets valid itself
            if (m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        case (cmd.op)
                            OP_TICK: begin
                                elapsed_reg <= elapsed_inc;
                                if (!due) begin
                                    rate_cnt_reg <= rate_inc;
                                end else begin
                                    rate_cnt_reg <= '0;
                                    if (!finished) begin
                                        state_reg <= S_MUL;
                                    end else if (count_reg != '0) begin
                                        state_reg <= S_POP;
                                    end
                                end
                            end
                            OP_JUMP: begin
                                head_reg     <= '0;
                                count_reg    <= '0;
                                rate_cnt_reg <= '0;
                                origin_reg   <= cmd.target;
                                target_reg   <= cmd.target;
                                dur_reg      <= '0;
                                elapsed_reg  <= '0;
                                result_reg   <= cmd.target;
                                state_reg    <= S_EMIT;
                            end
                            OP_NEW_LIST: begin
                                head_reg     <= '0;
                                count_reg    <= QCNT_W'(1);
                                rate_cnt_reg <= '0;
                            end
                            OP_APPEND: begin
                                if (count_reg < QDEPTH_CNT) begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                head_reg  <= '0;
                                count_reg <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_POP: begin
                    head_reg    <= head_inc;
                    count_reg   <= count_reg - 1'b1;
                    elapsed_reg <= '0;
                    target_reg  <= rd_reg.target;
                    dur_reg     <= rd_reg.duration;
                    if (rd_reg.duration == '0) begin
                        origin_reg <= rd_reg.target;
                        result_reg <= rd_reg.target;
                    end else begin
                        // ramp starts at the previous target
                        origin_reg <= target_reg;
                        result_reg <= target_reg;
                    end
                    state_reg <= S_EMIT;
                end
                S_MUL: begin
                    prod_reg  <= prod_full[PROD_W-1:0];
                    state_reg <= S_DSTART;
                end
                S_DSTART: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        result_reg <= origin_reg + quotient[VALUE_W-1:0];
                        state_reg  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= result_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ramp_value = m_value_reg;
    assign q_count      = count_reg;

endmodule

@@ rtl/core/segment_ramp_generator_top.sv @@
// From input transaction to result: a jump passes the idle and emit states, a segment
// start the idle, pop and emit states, an interpolated value the idle, multiply, divider
// start, divide and emit states; the divide state runs the 2-bit-per-cycle divider over
// the 48-bit product magnitude. The back end works one item at a time; an item that
// emits nothing takes only the idle state; the emit state waits for a free output.
// Reset (aresetn, synchronous, active low) clears all control and segment state and
// sets rate_ms to 20; segment queue contents are not cleared and need no clearing pass.
module segment_ramp_generator_top import srg_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [RATE_W-1:0]         cfg_rate_ms,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_action,
    input  logic signed [VALUE_W-1:0] s_target_value,
    input  logic [DUR_W-1:0]          s_duration_ms,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_ramp_value
);

    logic [RATE_W-1:0] rate_ms_reg;
    logic              cmd_valid;
    cmd_t              cmd;
    logic              cmd_pop;
    logic [QCNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_ms_reg <= RATE_RESET;
        end else if (cfg_valid) begin
            rate_ms_reg <= cfg_rate_ms;
        end
    end

    srg_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_target_value (s_target_value),
        .s_duration_ms  (s_duration_ms),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop)
    );

    srg_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rate_ms      (rate_ms_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ramp_value (m_ramp_value),
        .q_count      (q_count)
    );

    a_qcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QDEPTH_CNT)
        else $error("segment queue count exceeds depth");

    a_full_has_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> cmd_valid)
        else $error("front stalls with an empty command queue");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid)
        else $error("back end pops an empty command queue");

endmodule

@@ bench/tb_segment_ramp_generator_top.sv @@
// Self-checking bench for the segment ramp generator: random traffic with a scoreboard.
module tb_segment_ramp_generator_top;
    import srg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;

    class ramp_scoreboard;
        int                        errors;
        int                        rate;
        logic signed [VALUE_W-1:0] origin, target;
        int                        dur, elapsed, rate_cnt;
        logic signed [VALUE_W-1:0] q_tgt [QUEUE_DEPTH];
        int                        q_dur [QUEUE_DEPTH];
        int                        q_head, q_cnt;
        logic signed [VALUE_W-1:0] ramp_values_due[$];

        function new();
            errors = 0;
            rate = RATE_RESET;
            origin = 0;
            target = 0;
            dur = 0;
            elapsed = 0;
            rate_cnt = 0;
            q_head = 0;
            q_cnt = 0;
        endfunction

        function int pending();
            return ramp_values_due.size();
        endfunction

        function void set_rate(int r);
            rate = r;
        endfunction

        function void add_due(logic signed [VALUE_W-1:0] v);
            ramp_values_due.insert(ramp_values_due.size(), v);
        endfunction

        function bit seg_done();
            return dur == 0 || elapsed > dur || elapsed >= 65535;
        endfunction

        function void push_seg(logic signed [VALUE_W-1:0] t, int d);
            int slot;
            if (q_cnt >= QUEUE_DEPTH) return;
            slot = (q_head + q_cnt) % QUEUE_DEPTH;
            q_tgt[slot] = t;
            q_dur[slot] = d;
            q_cnt++;
        endfunction

        // Note an accepted input transaction and queue the value it emits, if any.
        function void note_item(logic [2:0] act, logic signed [VALUE_W-1:0] t, int d);
            longint step;
            int     slot;
            case (act)
                OP_TICK: begin
                    if (elapsed < 65535) elapsed++;
                    rate_cnt++;
                    if (rate_cnt < rate) return;
                    rate_cnt = 0;
                    if (seg_done()) begin
                        if (q_cnt == 0) return;
                        slot = q_head;
                        q_head = (q_head + 1) % QUEUE_DEPTH;
                        q_cnt--;
                        if (q_dur[slot] == 0) begin
                            origin = q_tgt[slot];
                            target = q_tgt[slot];
                        end else begin
                            origin = target;
                            target = q_tgt[slot];
                        end
                        dur = q_dur[slot];
                        elapsed = 0;
                    end
                    if (seg_done()) begin
                        add_due(target);
                    end else begin
                        step = ((longint'(target) - longint'(origin)) * elapsed) / dur;
                        add_due(VALUE_W'(longint'(origin) + step));
                    end
                end
                OP_JUMP: begin
                    q_head = 0;
                    q_cnt = 0;
                    rate_cnt = 0;
                    origin = t;
                    target = t;
                    dur = 0;
                    elapsed = 0;
                    add_due(t);
                end
                OP_NEW_LIST: begin
                    q_head = 0;
                    q_cnt = 0;
                    rate_cnt = 0;
                    push_seg(t, d);
                end
                OP_APPEND: push_seg(t, d);
                OP_CLEAR: begin
                    q_head = 0;
                    q_cnt = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_value(logic signed [VALUE_W-1:0] v);
            logic signed [VALUE_W-1:0] exp_v;
            if (ramp_values_due.size() == 0) begin
                $error("ramp_value: no value expected, got %0d", v);
                errors++;
                return;
            end
            exp_v = ramp_values_due.pop_front();
            if (v !== exp_v) begin
                $error("ramp_value: expected %0d, got %0d", exp_v, v);
                errors++;
            end
        endfunction
    endclass

    logic                      aclk = 0;
    logic                      aresetn = 0;
    logic                      cfg_valid = 0;
    logic                      cfg_ready;
    logic [RATE_W-1:0]         cfg_rate_ms = '0;
    logic                      s_valid = 0;
    logic                      s_ready;
    logic [2:0]                s_action = '0;
    logic signed [VALUE_W-1:0] s_target_value = '0;
    logic [DUR_W-1:0]          s_duration_ms = '0;
    logic                      m_valid;
    logic                      m_ready = 0;
    logic signed [VALUE_W-1:0] m_ramp_value;

    ramp_scoreboard sb = new();
    int  burst_left = 0;
    bit  bursty = 1;
    bit  running = 0;
    int  idle_cycles = 0;
    int  rx_mode = 0;
    int  rx_left = 0;

    segment_ramp_generator_top uut (.*);

    always #10 aclk = ~aclk;

    // Receiver stall pattern: switch between always ready, random, and mostly stalled.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_value(m_ramp_value);
    end

    always @(posedge aclk) begin
        if (running) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_item(logic [2:0] act, logic signed [VALUE_W-1:0] t, int d);
        s_valid <= 1'b1;
        s_action <= act;
        s_target_value <= t;
        s_duration_ms <= DUR_W'(d);
        do @(posedge aclk); while (!s_ready);
        sb.note_item(act, t, d);
        if (!bursty) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Drop valid, let every expected value come back, then wait out the back end.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_rate(int r);
        drain();
        cfg_valid <= 1'b1;
        cfg_rate_ms <= RATE_W'(r);
        do @(posedge aclk); while (!cfg_ready);
        sb.set_rate(r);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_target();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 400000)) - 200000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_duration();
        case ($urandom_range(0, 9))
            0, 1: return 0;
            2: return 65535;
            3: return $urandom_range(0, 65535);
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    task automatic random_items(int n);
        int w;
        repeat (n) begin
            w = $urandom_range(0, 99);
            if (w < 58)      send_item(OP_TICK, pick_target(), pick_duration());
            else if (w < 76) send_item(OP_APPEND, pick_target(), pick_duration());
            else if (w < 85) send_item(OP_NEW_LIST, pick_target(), pick_duration());
            else if (w < 91) send_item(OP_JUMP, pick_target(), pick_duration());
            else if (w < 96) send_item(OP_CLEAR, pick_target(), pick_duration());
            else             send_item(3'($urandom_range(5, 7)), pick_target(), pick_duration());
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        running <= 1'b1;
        @(posedge aclk);

        // Reset rate of 20 ticks, then both value extremes by jump.
        send_item(OP_NEW_LIST, 32'sd1000, 4);
        repeat (20) send_item(OP_TICK, 0, 0);
        send_item(OP_JUMP, 32'sh7FFF_FFFF, 65535);
        send_item(OP_JUMP, 32'sh8000_0000, 0);

        write_rate(1);
        send_item(OP_NEW_LIST, 32'sh8000_0000, 0);
        send_item(OP_APPEND, 32'sh7FFF_FFFF, 3);
        repeat (5) send_item(OP_TICK, 32'shFFFF_FFFF, 16'hFFFF);
        for (int a = 5; a < 8; a++) send_item(3'(a), 32'sh5555_AAAA, 16'hA5A5);
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_TICK, 0, 0);
        // Overfill the queue: the last push is dropped.
        for (int i = 0; i <= QUEUE_DEPTH; i++) send_item(OP_APPEND, 32'(i * 65536), i % 3);
        repeat (QUEUE_DEPTH + 4) send_item(OP_TICK, 0, 0);

        write_rate(2);
        random_items(120);
        write_rate(0);
        random_items(100);
        write_rate(3);
        random_items(120);
        write_rate(7);
        random_items(100);

        // Slow rate, full-scale ramp with a zero-duration segment queued behind it, back to back.
        write_rate(25);
        bursty = 0;
        send_item(OP_NEW_LIST, 32'sh7FFF_FFFF, 40);
        send_item(OP_APPEND, 32'sh8000_0000, 0);
        repeat (100) send_item(OP_TICK, 0, 0);
        bursty = 1;

        write_rate(1);
        random_items(60);

        drain();
        if (sb.pending() != 0) sb.errors++;
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
